// ----- rtl/core/geo_box_to_tile_range_top_macros.svh -----
// Assertion macros for the tile range block.
`ifndef GEO_BOX_TO_TILE_RANGE_TOP_MACROS_SVH
`define GEO_BOX_TO_TILE_RANGE_TOP_MACROS_SVH
`ifndef SYNTH
`define GBT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GBT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBT_ASSERT(label, clk, rst_n, prop, msg)
`define GBT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/gbt_pkg.sv -----
`default_nettype none
package gbt_pkg;
	localparam int ANGLE_FRAC_BITS = 22;
	localparam logic [4:0] ZOOM_LIMIT = 5'd22;
	localparam int QB = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int LOG_STEPS = 30;
	localparam int ROW_LAT = 3 + CORDIC_STEPS + 3 + LOG_STEPS + 3;

	localparam logic signed [35:0] LNG_HALF = 36'sd180 <<< ANGLE_FRAC_BITS;
	localparam logic signed [35:0] LAT_HALF = 36'sd90 <<< ANGLE_FRAC_BITS;
	localparam logic signed [31:0] LAT_LIM = 32'sd85 <<< ANGLE_FRAC_BITS;
	localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
	localparam logic signed [33:0] CORDIC_START_X = 34'sd652032874;
	localparam logic [27:0] LN2_OVER_PI_Q30 = 28'd236905672;
	localparam logic [31:0] Q30_ONE = 32'd1 << QB;
	// floor(x/45) = (x * DIV45_MUL) >> DIV45_SHIFT for x < 2^31
	localparam logic [31:0] DIV45_MUL = 32'd3054198967;
	localparam int DIV45_SHIFT = 37;
	// 360 degrees = 45 * 2^COL_SHIFT units
	localparam int COL_SHIFT = 25;

	typedef struct packed {
		logic signed [31:0] lat_first;
		logic signed [31:0] lat_second;
		logic signed [31:0] lng_first;
		logic signed [31:0] lng_second;
		logic [4:0] zoom_level;
	} box_t;

	typedef struct packed {
		logic [21:0] col_low;
		logic [21:0] col_high;
		logic [21:0] row_low;
		logic [21:0] row_high;
	} tiles_t;

	// floored wrap into [-half, half], period 2*half; covers the full 32-bit range
	function automatic logic signed [31:0] wrap_angle(input logic signed [31:0] v,
		input logic signed [35:0] half);
		logic signed [35:0] vv;
		logic signed [35:0] u;
		logic signed [35:0] p;
		logic signed [35:0] r;
		logic signed [35:0] cand;
		logic signed [31:0] res;
		vv = 36'(v);
		p = half <<< 1;
		u = vv + half;
		r = u;
		for (int j = -3; j <= 3; j++) begin
			cand = u - p * 36'(j);
			if (cand >= 36'sd0 && cand < p)
				r = cand;
		end
		if (vv >= -half && vv <= half)
			res = v;
		else
			res = 32'(r - half);
		return res;
	endfunction

	function automatic logic [30:0] arc_angle(input int i);
		logic [30:0] a;
		case (i)
			0: a = 31'd843314857;
			1: a = 31'd497837829;
			2: a = 31'd263043837;
			3: a = 31'd133525159;
			4: a = 31'd67021687;
			5: a = 31'd33543516;
			6: a = 31'd16775851;
			7: a = 31'd8388437;
			8: a = 31'd4194283;
			9: a = 31'd2097149;
			default: a = 31'd1 << (QB - i);
		endcase
		return a;
	endfunction

	function automatic logic [5:0] lead_one(input logic [32:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++)
			if (v[i])
				p = 6'(i);
		return p;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/geo_box_to_tile_range_top.sv -----
`default_nettype none
// Web-mercator tile ranges of a latitude/longitude box. One box per cycle is
// taken on box_valid/box_ready while the skid register is empty; its column
// and row ranges leave on tiles_valid/tiles_ready behind the 30-stage
// rotation and the 30-stage squaring log2 on the latitude path. A box with a
// zoom above the limit is taken and gives no transfer. A skid register behind
// the output lets the pipeline run one more transfer while the output is held.
`include "geo_box_to_tile_range_top_macros.svh"
module geo_box_to_tile_range_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           box_valid,
	output logic           box_ready,
	input  gbt_pkg::box_t   box,
	output logic           tiles_valid,
	input  logic           tiles_ready,
	output gbt_pkg::tiles_t tiles
);
	import gbt_pkg::*;

	localparam int DLY = ROW_LAT - 4;

	typedef struct packed {
		logic [4:0] z;
		logic [21:0] cl;
		logic [21:0] ch;
	} pipe_t;

	logic en, accept;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [4:0] z_s1, z_s2, z_s3;
	logic [30:0] off1_s1, off2_s1;
	logic [25:0] m1_s2, m2_s2;
	logic [21:0] c1_s3, c2_s3;
	pipe_t p_s4;
	logic [DLY-1:0] dv_s;
	pipe_t dp_s [DLY];

	logic [62:0] mp1, mp2;
	logic [47:0] cw1, cw2;
	logic [22:0] cmask;
	logic [31:0] t1, t2;
	logic [53:0] rw1, rw2;
	logic [21:0] r1, r2;
	pipe_t tail;
	logic pv;
	tiles_t res;

	logic out_v_q, skid_v_q;
	tiles_t out_q, skid_q;

	assign en = !skid_v_q;
	assign box_ready = en;
	assign accept = box_valid && box_ready;

	assign mp1 = 63'(off1_s1) * 63'(DIV45_MUL);
	assign mp2 = 63'(off2_s1) * 63'(DIV45_MUL);
	assign cw1 = 48'(m1_s2) << z_s2;
	assign cw2 = 48'(m2_s2) << z_s2;
	assign cmask = (23'd1 << z_s2) - 23'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			dv_s <= '0;
		end else if (en) begin
			v_s1 <= accept && (box.zoom_level <= ZOOM_LIMIT);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			dv_s <= {dv_s[DLY-2:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= box.zoom_level;
			off1_s1 <= 31'(36'(wrap_angle(box.lng_first, LNG_HALF)) + LNG_HALF);
			off2_s1 <= 31'(36'(wrap_angle(box.lng_second, LNG_HALF)) + LNG_HALF);
			z_s2 <= z_s1;
			m1_s2 <= mp1[DIV45_SHIFT +: 26];
			m2_s2 <= mp2[DIV45_SHIFT +: 26];
			z_s3 <= z_s2;
			c1_s3 <= 22'(cw1[COL_SHIFT +: 23] & cmask);
			c2_s3 <= 22'(cw2[COL_SHIFT +: 23] & cmask);
			p_s4.z <= z_s3;
			p_s4.cl <= (c1_s3 < c2_s3) ? c1_s3 : c2_s3;
			p_s4.ch <= (c1_s3 < c2_s3) ? c2_s3 : c1_s3;
			dp_s[0] <= p_s4;
			for (int i = 1; i < DLY; i++)
				dp_s[i] <= dp_s[i-1];
		end
	end

	gbt_lat_row u_row1 (
		.clk (clk),
		.en  (en),
		.lat (box.lat_first),
		.t   (t1)
	);

	gbt_lat_row u_row2 (
		.clk (clk),
		.en  (en),
		.lat (box.lat_second),
		.t   (t2)
	);

	assign tail = dp_s[DLY-1];
	assign pv = dv_s[DLY-1];
	assign rw1 = 54'(t1) << tail.z;
	assign rw2 = 54'(t2) << tail.z;
	assign r1 = rw1[52:31];
	assign r2 = rw2[52:31];

	always_comb begin
		res.col_low = tail.cl;
		res.col_high = tail.ch;
		res.row_low = (r1 < r2) ? r1 : r2;
		res.row_high = (r1 < r2) ? r2 : r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (tiles_ready)
				skid_v_q <= 1'b0;
		end else if (pv) begin
			if (!out_v_q || tiles_ready)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (tiles_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (tiles_ready)
				out_q <= skid_q;
		end else if (pv) begin
			if (!out_v_q || tiles_ready)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign tiles_valid = out_v_q;
	assign tiles = out_q;

	`GBT_ASSERT_ALWAYS(a_skid_needs_out, clk, skid_v_q |-> out_v_q, "skid full with output empty")
	`GBT_ASSERT(a_ranges_ordered, clk, arst_n, out_v_q |-> (out_q.col_low <= out_q.col_high && out_q.row_low <= out_q.row_high), "range bounds out of order")
	`GBT_ASSERT(a_skid_fill, clk, arst_n, $rose(skid_v_q) |-> $past(out_v_q && !tiles_ready), "skid filled without a held output")
	`GBT_ASSERT(a_zoom_drop, clk, arst_n, (accept && box.zoom_level > ZOOM_LIMIT) |=> !v_s1, "zoom above limit entered pipeline")
endmodule
`default_nettype wire

// ----- rtl/core/gbt_lat_row.sv -----
`default_nettype none
module gbt_lat_row (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] lat,
	output logic [31:0]        t
);
	import gbt_pkg::*;

	localparam int NEG_LEN = ROW_LAT - 2;

	logic signed [31:0] wrap_s1;
	logic [28:0] mag_s2;
	logic [33:0] ang_s3;
	logic [NEG_LEN-1:0] neg_q;
	logic signed [31:0] clamp_c;
	logic [53:0] ang_prod;

	logic signed [33:0] cx_s [CORDIC_STEPS];
	logic signed [33:0] cy_s [CORDIC_STEPS];
	logic signed [33:0] ca_s [CORDIC_STEPS];

	logic [32:0] nv1_s, nv2_s, nvb1_s, nvb2_s;
	logic [5:0] lp1_s, lp2_s, pn1_s, pn2_s;
	logic [30:0] fn1_s, fn2_s;
	logic signed [34:0] sum_y, sum_x;

	logic [30:0] f1_s [LOG_STEPS];
	logic [30:0] f2_s [LOG_STEPS];
	logic [29:0] fr1_s [LOG_STEPS];
	logic [29:0] fr2_s [LOG_STEPS];
	logic [5:0] p1_s [LOG_STEPS];
	logic [5:0] p2_s [LOG_STEPS];

	logic [33:0] d_s;
	logic [30:0] q_s;
	logic [31:0] t_s;
	logic signed [6:0] ip1, ip2;
	logic signed [37:0] lg1, lg2, dd;
	logic [61:0] q_prod;

	assign clamp_c = (wrap_s1 > LAT_LIM) ? LAT_LIM : (wrap_s1 < -LAT_LIM) ? -LAT_LIM : wrap_s1;
	assign ang_prod = 54'(mag_s2) * 54'(DEG_TO_RAD_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			wrap_s1 <= wrap_angle(lat, LAT_HALF);
			neg_q <= {neg_q[NEG_LEN-2:0], clamp_c[31]};
			mag_s2 <= clamp_c[31] ? 29'(-clamp_c) : 29'(clamp_c);
			ang_s3 <= {3'b000, ang_prod[ANGLE_FRAC_BITS +: 31]};
		end
	end

	// rotation, one micro-rotation per stage
	for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
		logic signed [33:0] xin, yin, ain, da;
		if (gi == 0) begin : g_first
			assign xin = CORDIC_START_X;
			assign yin = '0;
			assign ain = $signed(ang_s3);
		end else begin : g_next
			assign xin = cx_s[gi-1];
			assign yin = cy_s[gi-1];
			assign ain = ca_s[gi-1];
		end
		assign da = $signed({3'b000, arc_angle(gi)});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!ain[33]) begin
					cx_s[gi] <= xin - (yin >>> gi);
					cy_s[gi] <= yin + (xin >>> gi);
					ca_s[gi] <= ain - da;
				end else begin
					cx_s[gi] <= xin + (yin >>> gi);
					cy_s[gi] <= yin - (xin >>> gi);
					ca_s[gi] <= ain + da;
				end
			end
		end
	end

	assign sum_y = 35'sd1073741824 + 35'(cy_s[CORDIC_STEPS-1]);
	assign sum_x = 35'(cx_s[CORDIC_STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			nv1_s <= (sum_y < 35'sd1) ? 33'd1 : sum_y[32:0];
			nv2_s <= (sum_x < 35'sd1) ? 33'd1 : sum_x[32:0];
			lp1_s <= lead_one(nv1_s);
			lp2_s <= lead_one(nv2_s);
			nvb1_s <= nv1_s;
			nvb2_s <= nv2_s;
			fn1_s <= (lp1_s >= 6'd30) ? 31'(nvb1_s >> (lp1_s - 6'd30))
				: 31'(nvb1_s << (6'd30 - lp1_s));
			fn2_s <= (lp2_s >= 6'd30) ? 31'(nvb2_s >> (lp2_s - 6'd30))
				: 31'(nvb2_s << (6'd30 - lp2_s));
			pn1_s <= lp1_s;
			pn2_s <= lp2_s;
		end
	end

	// log2 fraction, one squaring per stage
	for (genvar gk = 0; gk < LOG_STEPS; gk++) begin : g_log
		logic [30:0] fa, fb;
		logic [29:0] ra, rb;
		logic [5:0] pa, pb;
		logic [61:0] sa, sb;
		if (gk == 0) begin : g_first
			assign fa = fn1_s;
			assign fb = fn2_s;
			assign ra = '0;
			assign rb = '0;
			assign pa = pn1_s;
			assign pb = pn2_s;
		end else begin : g_next
			assign fa = f1_s[gk-1];
			assign fb = f2_s[gk-1];
			assign ra = fr1_s[gk-1];
			assign rb = fr2_s[gk-1];
			assign pa = p1_s[gk-1];
			assign pb = p2_s[gk-1];
		end
		assign sa = 62'(fa) * 62'(fa);
		assign sb = 62'(fb) * 62'(fb);
		always_ff @(posedge clk) begin
			if (en) begin
				f1_s[gk] <= sa[61] ? sa[61:31] : sa[60:30];
				f2_s[gk] <= sb[61] ? sb[61:31] : sb[60:30];
				fr1_s[gk] <= {ra[28:0], sa[61]};
				fr2_s[gk] <= {rb[28:0], sb[61]};
				p1_s[gk] <= pa;
				p2_s[gk] <= pb;
			end
		end
	end

	assign ip1 = $signed({1'b0, p1_s[LOG_STEPS-1]}) - 7'sd30;
	assign ip2 = $signed({1'b0, p2_s[LOG_STEPS-1]}) - 7'sd30;
	assign lg1 = 38'($signed({ip1, 30'd0})) + 38'({1'b0, fr1_s[LOG_STEPS-1]});
	assign lg2 = 38'($signed({ip2, 30'd0})) + 38'({1'b0, fr2_s[LOG_STEPS-1]});
	assign dd = lg1 - lg2;
	assign q_prod = 62'(d_s) * 62'(LN2_OVER_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= dd[37] ? '0 : dd[33:0];
			q_s <= (q_prod[61:30] > Q30_ONE) ? Q30_ONE[30:0] : q_prod[60:30];
			t_s <= neg_q[NEG_LEN-1] ? Q30_ONE + 32'(q_s) : Q30_ONE - 32'(q_s);
		end
	end

	assign t = t_s;
endmodule
`default_nettype wire
